// File: sv/vssg_pkg.sv
// Shared widths, codes, reset values and control types of the voice session silence gate.
package vssg_pkg;

	localparam int unsigned ACTION_W   = 3;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned EVENT_W    = 3;
	localparam int unsigned SEQ_W      = 32;
	localparam int unsigned THR_W      = 15;
	localparam int unsigned MS_W       = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned MAG_W      = SAMPLE_W + 1;
	localparam int unsigned MAGSQ_W    = 2 * SAMPLE_W - 1;
	localparam int unsigned THRSQ_W    = 2 * THR_W;

	localparam int unsigned MAX_FRAME_DEF = 512;

	localparam logic [THR_W-1:0] THR_RST     = 15'd1500;
	localparam logic [MS_W-1:0]  TIMEOUT_RST = 16'd3000;
	localparam logic [MS_W-1:0]  MAXSESS_RST = 16'd10000;

	localparam logic [ACTION_W-1:0] ACT_SAMPLE = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_WAKE   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_CANCEL = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_START  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd5;

	localparam logic [EVENT_W-1:0] EV_SEND    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_STARTED = 3'd1;
	localparam logic [EVENT_W-1:0] EV_SILENCE = 3'd2;
	localparam logic [EVENT_W-1:0] EV_MAXSESS = 3'd3;
	localparam logic [EVENT_W-1:0] EV_CANCEL  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXSESS   = 2'd2;

	typedef struct packed {
		logic go;
		logic sample;
		logic last;
		logic clear;
	} frm_ctl_t;

	typedef struct packed {
		logic frame_end;
		logic quiet;
	} frm_sts_t;

endpackage

// File: sv/vssg_if.sv
// Request, result and configuration channel interfaces of the voice session silence gate.
interface vssg_in_if;
	logic                                valid;
	logic                                ready;
	logic [vssg_pkg::ACTION_W-1:0]       action;
	logic signed [vssg_pkg::SAMPLE_W-1:0] sample;
	logic                                last_of_frame;
	modport source(output valid, action, sample, last_of_frame, input ready);
	modport sink(input valid, action, sample, last_of_frame, output ready);
endinterface

interface vssg_out_if;
	logic                         valid;
	logic                         ready;
	logic [vssg_pkg::EVENT_W-1:0] event_res;
	logic [vssg_pkg::SEQ_W-1:0]   sequence_res;
	logic                         frame_quiet;
	modport source(output valid, event_res, sequence_res, frame_quiet, input ready);
	modport sink(input valid, event_res, sequence_res, frame_quiet, output ready);
endinterface

interface vssg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [vssg_pkg::CFG_IDX_W-1:0]  index;
	logic [vssg_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: sv/voice_session_silence_gate_unit.sv
// Top level of the voice session controller with its frame energy silence gate.
// A request enters the input stage; its result is then registered and driven on evt.
// One request per cycle unless the input stage stalls; each updates the session state.
// A request that makes a result waits in the input stage while an earlier result is held
// on evt; a request that makes no result moves on and never stalls.
// Reset (arst_n low, asynchronous) clears the mode to disabled, all counters and the
// frame sum, and loads the register reset values; the input is ready when the input stage is empty.
module voice_session_silence_gate_unit #(
	parameter int unsigned MAX_FRAME = vssg_pkg::MAX_FRAME_DEF
) (
	input logic         clk,
	input logic         arst_n,
	vssg_in_if.sink     mic,
	vssg_out_if.source  evt,
	vssg_cfg_if.sink    cfg
);

	typedef enum logic [1:0] {
		MODE_DISABLED,
		MODE_IDLE,
		MODE_ACTIVE
	} mode_t;

	// Configuration registers. Writes are always taken.
	logic [vssg_pkg::THR_W-1:0] thr_q;
	logic [vssg_pkg::MS_W-1:0]  timeout_q;
	logic [vssg_pkg::MS_W-1:0]  maxsess_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= vssg_pkg::THR_RST;
			timeout_q <= vssg_pkg::TIMEOUT_RST;
			maxsess_q <= vssg_pkg::MAXSESS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				vssg_pkg::CFG_THRESHOLD: thr_q     <= cfg.data[vssg_pkg::THR_W-1:0];
				vssg_pkg::CFG_TIMEOUT:   timeout_q <= cfg.data[vssg_pkg::MS_W-1:0];
				vssg_pkg::CFG_MAXSESS:   maxsess_q <= cfg.data[vssg_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage. The sample magnitude is squared on the way in, so the stage
	// after it only has to accumulate and compare.
	logic                          valid_s1;
	logic [vssg_pkg::ACTION_W-1:0] action_s1;
	logic                          last_s1;
	logic [vssg_pkg::MAGSQ_W-1:0]  magsq_s1;

	logic signed [vssg_pkg::MAG_W-1:0] sample_ext;
	logic [vssg_pkg::MAG_W-1:0]        mag;
	logic [2*vssg_pkg::MAG_W-1:0]      mag_prod;

	always_comb begin
		sample_ext = vssg_pkg::MAG_W'(mic.sample);
		mag        = sample_ext[vssg_pkg::MAG_W-1] ? vssg_pkg::MAG_W'(-sample_ext)
		                                           : vssg_pkg::MAG_W'(sample_ext);
		mag_prod   = (2*vssg_pkg::MAG_W)'(mag) * (2*vssg_pkg::MAG_W)'(mag);
	end

	// Session state and the result register.
	mode_t                      mode_q;
	logic [vssg_pkg::MS_W-1:0]  sess_q;
	logic                       armed_q;
	logic [vssg_pkg::MS_W-1:0]  sil_q;
	logic [vssg_pkg::SEQ_W-1:0] fseq_q;
	logic                       evt_valid_q;
	logic [vssg_pkg::EVENT_W-1:0] ev_q;
	logic [vssg_pkg::SEQ_W-1:0] seqo_q;
	logic                       quiet_q;

	mode_t                      mode_n;
	logic [vssg_pkg::MS_W-1:0]  sess_n;
	logic                       armed_n;
	logic [vssg_pkg::MS_W-1:0]  sil_n;
	logic [vssg_pkg::SEQ_W-1:0] fseq_n;
	logic                       emit;
	logic [vssg_pkg::EVENT_W-1:0] ev_n;
	logic [vssg_pkg::SEQ_W-1:0] seqo_n;
	logic                       quiet_n;

	logic out_free;
	logic go_s1;

	vssg_pkg::frm_ctl_t frm_ctl;
	vssg_pkg::frm_sts_t frm_sts;

	vssg_frame_energy #(
		.MAX_FRAME(MAX_FRAME)
	) u_energy (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (frm_ctl),
		.magsq (magsq_s1),
		.thr   (thr_q),
		.sts   (frm_sts)
	);

	// The staged request moves on when it makes no result or the result slot is free.
	assign out_free  = !evt_valid_q || evt.ready;
	assign go_s1     = valid_s1 && (!emit || out_free);
	assign mic.ready = !valid_s1 || go_s1;

	always_comb begin
		frm_ctl.go     = go_s1;
		frm_ctl.sample = valid_s1 && (action_s1 == vssg_pkg::ACT_SAMPLE)
		                 && (mode_q == MODE_ACTIVE);
		frm_ctl.last   = last_s1;
		frm_ctl.clear  = ((action_s1 == vssg_pkg::ACT_WAKE) && (mode_q == MODE_IDLE))
		                 || ((action_s1 == vssg_pkg::ACT_CANCEL) && (mode_q == MODE_ACTIVE))
		                 || (action_s1 == vssg_pkg::ACT_STOP);
	end

	// Next session state and the result of the staged request.
	always_comb begin
		mode_n  = mode_q;
		sess_n  = sess_q;
		armed_n = armed_q;
		sil_n   = sil_q;
		fseq_n  = fseq_q;
		emit    = 1'b0;
		ev_n    = vssg_pkg::EV_SEND;
		seqo_n  = '0;
		quiet_n = 1'b0;
		if (valid_s1) begin
			case (action_s1)
				vssg_pkg::ACT_SAMPLE: begin
					if (frm_sts.frame_end) begin
						emit    = 1'b1;
						quiet_n = frm_sts.quiet;
						// The session cap is tested before the silence rule.
						if (sess_q >= maxsess_q) begin
							mode_n = MODE_IDLE;
							ev_n   = vssg_pkg::EV_MAXSESS;
						end else if (frm_sts.quiet && armed_q && (sil_q >= timeout_q)) begin
							mode_n = MODE_IDLE;
							ev_n   = vssg_pkg::EV_SILENCE;
						end else begin
							// The first quiet frame arms the timer; a loud one disarms it.
							if (!frm_sts.quiet || !armed_q) begin
								sil_n = '0;
							end
							armed_n = frm_sts.quiet;
							ev_n    = vssg_pkg::EV_SEND;
							seqo_n  = fseq_q;
							fseq_n  = fseq_q + vssg_pkg::SEQ_W'(1);
						end
					end
				end
				vssg_pkg::ACT_TICK: begin
					if (mode_q == MODE_ACTIVE) begin
						if (sess_q != '1) begin
							sess_n = sess_q + vssg_pkg::MS_W'(1);
						end
						if (armed_q && (sil_q != '1)) begin
							sil_n = sil_q + vssg_pkg::MS_W'(1);
						end
					end
				end
				vssg_pkg::ACT_WAKE: begin
					if (mode_q == MODE_IDLE) begin
						mode_n  = MODE_ACTIVE;
						sess_n  = '0;
						armed_n = 1'b0;
						sil_n   = '0;
						fseq_n  = '0;
						emit    = 1'b1;
						ev_n    = vssg_pkg::EV_STARTED;
					end
				end
				vssg_pkg::ACT_CANCEL: begin
					if (mode_q == MODE_ACTIVE) begin
						mode_n = MODE_IDLE;
						emit   = 1'b1;
						ev_n   = vssg_pkg::EV_CANCEL;
					end
				end
				vssg_pkg::ACT_START: begin
					if (mode_q == MODE_DISABLED) begin
						mode_n = MODE_IDLE;
					end
				end
				vssg_pkg::ACT_STOP: begin
					mode_n = MODE_DISABLED;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (mic.valid && mic.ready) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mic.valid && mic.ready) begin
			action_s1 <= mic.action;
			last_s1   <= mic.last_of_frame;
			magsq_s1  <= mag_prod[vssg_pkg::MAGSQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_DISABLED;
			sess_q      <= '0;
			armed_q     <= 1'b0;
			sil_q       <= '0;
			fseq_q      <= '0;
			evt_valid_q <= 1'b0;
			ev_q        <= vssg_pkg::EV_SEND;
			seqo_q      <= '0;
			quiet_q     <= 1'b0;
		end else begin
			if (go_s1) begin
				mode_q  <= mode_n;
				sess_q  <= sess_n;
				armed_q <= armed_n;
				sil_q   <= sil_n;
				fseq_q  <= fseq_n;
			end
			if (go_s1 && emit) begin
				evt_valid_q <= 1'b1;
				ev_q        <= ev_n;
				seqo_q      <= seqo_n;
				quiet_q     <= quiet_n;
			end else if (evt.ready) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	assign evt.valid        = evt_valid_q;
	assign evt.event_res    = ev_q;
	assign evt.sequence_res = seqo_q;
	assign evt.frame_quiet  = quiet_q;

endmodule

// File: sv/vssg_frame_energy.sv
// Frame energy accumulator and quiet test against threshold squared times sample count.
module vssg_frame_energy #(
	parameter int unsigned MAX_FRAME = vssg_pkg::MAX_FRAME_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vssg_pkg::frm_ctl_t           ctl,
	input  logic [vssg_pkg::MAGSQ_W-1:0] magsq,
	input  logic [vssg_pkg::THR_W-1:0]   thr,
	output vssg_pkg::frm_sts_t           sts
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
	localparam int unsigned SUM_W = vssg_pkg::MAGSQ_W + $clog2(MAX_FRAME);
	localparam int unsigned LIM_W = vssg_pkg::THRSQ_W + CNT_W;
	localparam int unsigned CMP_W = vssg_pkg::MAGSQ_W + CNT_W;

	logic [CNT_W-1:0]             cnt_q;
	logic [SUM_W-1:0]             sum_q;
	logic [vssg_pkg::THRSQ_W-1:0] thrsq_q;
	logic [CNT_W-1:0]             cnt_new;
	logic [SUM_W-1:0]             sum_new;
	logic [LIM_W-1:0]             lim;

	always_comb begin
		cnt_new       = cnt_q + CNT_W'(1);
		sum_new       = sum_q + SUM_W'(magsq);
		lim           = LIM_W'(thrsq_q) * LIM_W'(cnt_new);
		sts.frame_end = ctl.sample && (ctl.last || (cnt_new == CNT_W'(MAX_FRAME)));
		sts.quiet     = CMP_W'(sum_new) < CMP_W'(lim);
	end

	// Registered thr squared; configuration settles while idle, by the user, unchecked.
	always_ff @(posedge clk) begin
		thrsq_q <= vssg_pkg::THRSQ_W'(thr) * vssg_pkg::THRSQ_W'(thr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (ctl.go) begin
			if (ctl.sample) begin
				if (sts.frame_end) begin
					cnt_q <= '0;
					sum_q <= '0;
				end else begin
					cnt_q <= cnt_new;
					sum_q <= sum_new;
				end
			end else if (ctl.clear) begin
				cnt_q <= '0;
				sum_q <= '0;
			end
		end
	end

endmodule

// File: sv/vssg_checker.sv
// Port-level assertions on the result channel of the voice session silence gate, with its bind.
module vssg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         evt_valid,
	input logic                         evt_ready,
	input logic [vssg_pkg::EVENT_W-1:0] event_res,
	input logic [vssg_pkg::SEQ_W-1:0]   sequence_res,
	input logic                         frame_quiet
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(event_res)
		&& $stable(sequence_res) && $stable(frame_quiet))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> (event_res == vssg_pkg::EV_SEND) || (event_res == vssg_pkg::EV_STARTED)
		|| (event_res == vssg_pkg::EV_SILENCE) || (event_res == vssg_pkg::EV_MAXSESS)
		|| (event_res == vssg_pkg::EV_CANCEL))
		else $error("undefined event code");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (event_res != vssg_pkg::EV_SEND) |-> (sequence_res == '0))
		else $error("sequence number on a non-send event");

	a_noq: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && ((event_res == vssg_pkg::EV_STARTED) || (event_res == vssg_pkg::EV_CANCEL))
		|-> !frame_quiet)
		else $error("quiet flag on a session start or cancel");

	a_silq: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (event_res == vssg_pkg::EV_SILENCE) |-> frame_quiet)
		else $error("silence stop from a loud frame");

endmodule

bind voice_session_silence_gate_unit vssg_checker u_vssg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.evt_valid   (evt.valid),
	.evt_ready   (evt.ready),
	.event_res   (evt.event_res),
	.sequence_res(evt.sequence_res),
	.frame_quiet (evt.frame_quiet)
);
